// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared request and response types for the strongly connected component block
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int FIELD_W = 11;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] src_node;
    logic [FIELD_W-1:0] dst_node;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sink_node_count;
    logic [FIELD_W-1:0] component_count;
    logic               edge_overflow;
  } out_t;

endpackage

// ===== rtl/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/scc_seq.sv =====
// ----------------------------------------------------------------------------
// scc_seq
// sequencer: edge loading, iterative tarjan walk, sink marking, clearing pass
// ----------------------------------------------------------------------------
module scc_seq #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [scc_pkg::FIELD_W-1:0] node_count_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  scc_pkg::in_t           in_req_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output scc_pkg::out_t          res_o
);
  import scc_pkg::*;

  localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int VW  = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int KW  = (VW > FIELD_W) ? VW : FIELD_W;
  localparam int FW  = 3 * VW + EW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_EA1, S_EA2, S_RCHK1, S_RCHK2, S_EN1, S_EN2,
    S_WTOP, S_WE1, S_WE2, S_WV1, S_WV2, S_P1, S_P2, S_RET1, S_RET2,
    S_M1, S_M2, S_MTOP, S_M3, S_M4, S_M5, S_M6, S_S1, S_S2, S_OUT
  } state_e;

  state_e         st_q;
  logic [EW-1:0]  cnt_q, e_q;
  logic           ovf_q;
  logic [VW-1:0]  ord_q, comp_q, top_q, depth_q, i_q, x_q, u_q, lo_q, od_q;
  logic [VW-1:0]  v_q, ci_q, sz_q, sink_sz_q, n_q, src_q, dst_q;
  logic [1:0]     sinks_q;
  logic [NAW-1:0] clr_q;

  // memory ports
  logic           head_we, vord_we, onstk_we, nstk_we, frm_we, comp_we, csz_we, hout_we;
  logic           edge_we;
  logic [NAW-1:0] head_wa, head_ra, vord_wa, vord_ra, onstk_wa, onstk_ra;
  logic [NAW-1:0] nstk_wa, nstk_ra, frm_wa, frm_ra, comp_wa, comp_ra;
  logic [NAW-1:0] csz_wa, csz_ra, hout_wa, hout_ra;
  logic [EAW-1:0] edge_wa, edge_ra;
  logic [EW-1:0]  head_wd, head_rd, link_wd, link_rd;
  logic [VW-1:0]  vord_wd, vord_rd, nstk_wd, nstk_rd, comp_wd, comp_rd;
  logic [VW-1:0]  csz_wd, csz_rd, tgt_wd, tgt_rd;
  logic           onstk_wd, onstk_rd, hout_wd, hout_rd;
  logic [FW-1:0]  frm_wd, frm_rd;

  logic [VW-1:0]  ord_inc, sz_inc, n_clamp, new_top;
  logic [EW-1:0]  cnt_inc;
  logic           add_ok, i_last;

  function automatic logic [NAW-1:0] nidx(input logic [VW-1:0] x);
    logic [VW-1:0] t;
    t = x - VW'(1);
    return t[NAW-1:0];
  endfunction

  function automatic logic [EAW-1:0] eidx(input logic [EW-1:0] x);
    logic [EW-1:0] t;
    t = x - EW'(1);
    return t[EAW-1:0];
  endfunction

  assign ord_inc = ord_q + VW'(1);
  assign sz_inc  = sz_q + VW'(1);
  assign cnt_inc = cnt_q + EW'(1);
  assign new_top = top_q - VW'(1);
  assign i_last  = (i_q == n_q);
  assign n_clamp = (KW'(node_count_i) > KW'(MAX_NODES)) ? VW'(MAX_NODES)
                                                       : VW'(node_count_i);
  assign add_ok  = (in_req_i.src_node != '0) && (in_req_i.dst_node != '0) &&
                   (KW'(in_req_i.src_node) <= KW'(MAX_NODES)) &&
                   (KW'(in_req_i.dst_node) <= KW'(MAX_NODES));

  assign in_ready_o  = (st_q == S_IDLE);
  assign res_valid_o = (st_q == S_OUT);
  assign res_o.sink_node_count = (sinks_q == 2'd1) ? FIELD_W'(sink_sz_q) : '0;
  assign res_o.component_count = FIELD_W'(comp_q);
  assign res_o.edge_overflow   = ovf_q;

  always_comb begin
    head_we = 1'b0;  head_wa = clr_q;  head_wd = '0;  head_ra = nidx(i_q);
    vord_we = 1'b0;  vord_wa = clr_q;  vord_wd = '0;  vord_ra = nidx(i_q);
    onstk_we = 1'b0; onstk_wa = clr_q; onstk_wd = 1'b0; onstk_ra = nidx(v_q);
    nstk_we = 1'b0;  nstk_wa = top_q[NAW-1:0]; nstk_wd = x_q; nstk_ra = nidx(top_q);
    frm_we = 1'b0;   frm_wa = nidx(depth_q); frm_wd = {u_q, e_q, lo_q, od_q};
    frm_ra = nidx(depth_q - VW'(1));
    comp_we = 1'b0;  comp_wa = nidx(nstk_rd); comp_wd = comp_q; comp_ra = nidx(i_q);
    csz_we = 1'b0;   csz_wa = clr_q;  csz_wd = '0;  csz_ra = nidx(i_q);
    hout_we = 1'b0;  hout_wa = clr_q; hout_wd = 1'b0; hout_ra = nidx(i_q);
    edge_we = 1'b0;  edge_wa = cnt_q[EAW-1:0]; tgt_wd = dst_q; link_wd = head_rd;
    edge_ra = eidx(e_q);
    unique case (st_q)
      S_CLR: begin
        head_we = 1'b1; vord_we = 1'b1; onstk_we = 1'b1; csz_we = 1'b1; hout_we = 1'b1;
      end
      S_EA1: head_ra = nidx(src_q);
      S_EA2: begin
        edge_we = 1'b1;
        head_we = 1'b1; head_wa = nidx(src_q); head_wd = cnt_inc;
      end
      S_EN1: head_ra = nidx(x_q);
      S_EN2: begin
        vord_we = 1'b1; vord_wa = nidx(x_q); vord_wd = ord_inc;
        onstk_we = 1'b1; onstk_wa = nidx(x_q); onstk_wd = 1'b1;
        nstk_we = 1'b1;
      end
      S_WV1: vord_ra = nidx(v_q);
      S_WV2: frm_we = (vord_rd == '0);
      S_P2: begin
        onstk_we = 1'b1; onstk_wa = nidx(nstk_rd);
        comp_we = 1'b1;
        csz_we = (nstk_rd == u_q); csz_wa = nidx(comp_q); csz_wd = sz_inc;
      end
      S_M5: comp_ra = nidx(v_q);
      S_M6: begin
        hout_we = (comp_rd != ci_q); hout_wa = nidx(ci_q); hout_wd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      ord_q <= '0; comp_q <= '0; top_q <= '0; depth_q <= '0; sinks_q <= '0;
    end else begin
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + NAW'(1);
          if (clr_q == NAW'(MAX_NODES - 1)) begin
            st_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_req_i.req_type == REQ_RUN) begin
              n_q <= n_clamp; i_q <= VW'(1); sinks_q <= '0;
              st_q <= (n_clamp == '0) ? S_OUT : S_RCHK1;
            end else if (add_ok) begin
              if (cnt_q == EW'(MAX_EDGES)) begin
                ovf_q <= 1'b1;
              end else begin
                src_q <= VW'(in_req_i.src_node);
                dst_q <= VW'(in_req_i.dst_node);
                st_q  <= S_EA1;
              end
            end
          end
        end
        S_EA1: st_q <= S_EA2;
        S_EA2: begin
          cnt_q <= cnt_inc;
          st_q  <= S_IDLE;
        end
        S_RCHK1: st_q <= S_RCHK2;
        S_RCHK2: begin
          if (vord_rd == '0) begin
            x_q <= i_q; st_q <= S_EN1;
          end else if (i_last) begin
            i_q <= VW'(1); st_q <= S_M1;
          end else begin
            i_q <= i_q + VW'(1); st_q <= S_RCHK1;
          end
        end
        S_EN1: st_q <= S_EN2;
        S_EN2: begin
          ord_q <= ord_inc; u_q <= x_q; e_q <= head_rd; lo_q <= ord_inc; od_q <= ord_inc;
          top_q <= top_q + VW'(1); depth_q <= depth_q + VW'(1);
          st_q <= S_WTOP;
        end
        S_WTOP: begin
          if (e_q != '0) begin
            st_q <= S_WE1;
          end else if (lo_q == od_q) begin
            comp_q <= comp_q + VW'(1); sz_q <= '0; st_q <= S_P1;
          end else begin
            st_q <= S_RET1;
          end
        end
        S_WE1: st_q <= S_WE2;
        S_WE2: begin
          e_q <= link_rd; v_q <= tgt_rd;
          st_q <= (tgt_rd == '0 || tgt_rd > n_q) ? S_WTOP : S_WV1;
        end
        S_WV1: st_q <= S_WV2;
        S_WV2: begin
          if (vord_rd == '0) begin
            x_q <= v_q; st_q <= S_EN1;
          end else begin
            if (onstk_rd && vord_rd < lo_q) begin
              lo_q <= vord_rd;
            end
            st_q <= S_WTOP;
          end
        end
        S_P1: begin
          top_q <= new_top; st_q <= S_P2;
        end
        S_P2: begin
          sz_q <= sz_inc;
          st_q <= (nstk_rd == u_q) ? S_RET1 : S_P1;
        end
        S_RET1: begin
          depth_q <= depth_q - VW'(1);
          if (depth_q == VW'(1)) begin
            if (i_last) begin
              i_q <= VW'(1); st_q <= S_M1;
            end else begin
              i_q <= i_q + VW'(1); st_q <= S_RCHK1;
            end
          end else begin
            st_q <= S_RET2;
          end
        end
        S_RET2: begin
          u_q  <= frm_rd[FW-1 -: VW];
          e_q  <= frm_rd[2*VW+EW-1 -: EW];
          od_q <= frm_rd[VW-1:0];
          lo_q <= (lo_q < frm_rd[2*VW-1 -: VW]) ? lo_q : frm_rd[2*VW-1 -: VW];
          st_q <= S_WTOP;
        end
        S_M1: st_q <= S_M2;
        S_M2: begin
          e_q <= head_rd; ci_q <= comp_rd; st_q <= S_MTOP;
        end
        S_MTOP: begin
          if (e_q != '0) begin
            st_q <= S_M3;
          end else if (!i_last) begin
            i_q <= i_q + VW'(1); st_q <= S_M1;
          end else begin
            i_q <= VW'(1);
            st_q <= (comp_q == '0) ? S_OUT : S_S1;
          end
        end
        S_M3: st_q <= S_M4;
        S_M4: begin
          e_q <= link_rd; v_q <= tgt_rd;
          st_q <= (tgt_rd == '0 || tgt_rd > n_q) ? S_MTOP : S_M5;
        end
        S_M5: st_q <= S_M6;
        S_M6: st_q <= S_MTOP;
        S_S1: st_q <= S_S2;
        S_S2: begin
          if (!hout_rd) begin
            sink_sz_q <= csz_rd;
            if (sinks_q != 2'd2) begin
              sinks_q <= sinks_q + 2'd1;
            end
          end
          if (i_q == comp_q) begin
            st_q <= S_OUT;
          end else begin
            i_q <= i_q + VW'(1); st_q <= S_S1;
          end
        end
        S_OUT: begin
          if (res_ready_i) begin
            st_q <= S_CLR; clr_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
            ord_q <= '0; comp_q <= '0; top_q <= '0; depth_q <= '0;
          end
        end
        default: st_q <= S_CLR;
      endcase
    end
  end

  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(EW)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(VW)) u_vord (
    .clk_i, .we_i(vord_we), .waddr_i(vord_wa), .wdata_i(vord_wd),
    .raddr_i(vord_ra), .rdata_o(vord_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_onstk (
    .clk_i, .we_i(onstk_we), .waddr_i(onstk_wa), .wdata_i(onstk_wd),
    .raddr_i(onstk_ra), .rdata_o(onstk_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(VW)) u_nstk (
    .clk_i, .we_i(nstk_we), .waddr_i(nstk_wa), .wdata_i(nstk_wd),
    .raddr_i(nstk_ra), .rdata_o(nstk_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(FW)) u_frame (
    .clk_i, .we_i(frm_we), .waddr_i(frm_wa), .wdata_i(frm_wd),
    .raddr_i(frm_ra), .rdata_o(frm_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(VW)) u_compof (
    .clk_i, .we_i(comp_we), .waddr_i(comp_wa), .wdata_i(comp_wd),
    .raddr_i(comp_ra), .rdata_o(comp_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(VW)) u_csize (
    .clk_i, .we_i(csz_we), .waddr_i(csz_wa), .wdata_i(csz_wd),
    .raddr_i(csz_ra), .rdata_o(csz_rd));
  scc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_hasout (
    .clk_i, .we_i(hout_we), .waddr_i(hout_wa), .wdata_i(hout_wd),
    .raddr_i(hout_ra), .rdata_o(hout_rd));
  scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(VW)) u_etgt (
    .clk_i, .we_i(edge_we), .waddr_i(edge_wa), .wdata_i(tgt_wd),
    .raddr_i(edge_ra), .rdata_o(tgt_rd));
  scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(EW)) u_elink (
    .clk_i, .we_i(edge_we), .waddr_i(edge_wa), .wdata_i(link_wd),
    .raddr_i(edge_ra), .rdata_o(link_rd));

`ifndef ASSERT_OFF
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> (top_q == '0 && depth_q == '0))
    else $error("stack not drained at idle");
  a_run_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.req_type == REQ_RUN) |=> (st_q != S_IDLE))
    else $error("run request did not start");
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q <= VW'(MAX_NODES)))
    else $error("node stack overrun");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= EW'(MAX_EDGES)))
    else $error("edge store overrun");
`endif

endmodule

// ===== rtl/scc_sink_component_count.sv =====
// ----------------------------------------------------------------------------
// scc_sink_component_count
// strongly connected components of a loaded graph with a unique-sink report
//
// in channel: requests with req_type add one edge or run the analysis.
// an edge request reads the source head, then writes the edge and head; edges with an
// endpoint of zero or above MAX_NODES are ignored, edges past MAX_EDGES are
// dropped and flagged in edge_overflow.
// a run request walks the graph through the shared sequencer: it checks each
// node, enters the unvisited ones and walks their edges, pops each finished
// component off the node stack, then marks components with an outgoing edge
// in a pass over every node and edge and scans the components for sinks,
// then clears MAX_NODES entries. the block is not ready during all of this.
// out channel: one response per run, held in an output register; the
// sequencer waits in its final state while the receiver stalls.
// reset starts with the clearing pass; node_count = 1.
// cfg channel: writes node_count, always ready, write only while idle.
// ----------------------------------------------------------------------------
module scc_sink_component_count #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [scc_pkg::FIELD_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  scc_pkg::in_t                in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output scc_pkg::out_t               out_rsp_o
);
  import scc_pkg::*;

  logic [FIELD_W-1:0] node_count_q;
  logic               out_valid_q;
  out_t               out_q;
  logic               res_valid, res_ready;
  out_t               res;

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= FIELD_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  scc_seq #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_seq (
    .clk_i,
    .rst_ni,
    .node_count_i (node_count_q),
    .in_valid_i,
    .in_ready_o,
    .in_req_i,
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

endmodule

// ===== test/scc_sink_component_count_test.sv =====
// ----------------------------------------------------------------------------
// scc_sink_component_count_test
// drives edge and run requests into the component block, predicts each run
// result with a behavioral scc walk and compares responses in order
// ----------------------------------------------------------------------------
module scc_sink_component_count_test;
  import scc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES_CAP = 1024;
  localparam int EDGES_CAP = 8192;
  localparam longint CYCLE_LIMIT = 64'd40000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [FIELD_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_rsp_o;

  scc_sink_component_count dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_rsp_o(out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // graph mirror
  int unsigned g_target[EDGES_CAP+1];
  int unsigned g_link[EDGES_CAP+1];
  int unsigned g_head[NODES_CAP+1];
  int unsigned g_stored;
  bit g_overflow;
  int unsigned g_nodes;

  int unsigned w_order[NODES_CAP+1];
  int unsigned w_low[NODES_CAP+1];
  bit w_on[NODES_CAP+1];
  int unsigned w_stack[NODES_CAP+1];
  int unsigned w_top;
  int unsigned f_node[NODES_CAP+1];
  int unsigned f_edge[NODES_CAP+1];
  int unsigned w_comp[NODES_CAP+1];
  int unsigned c_size[NODES_CAP+2];
  bit c_out[NODES_CAP+2];
  int unsigned w_cnt;
  int unsigned c_cnt;

  in_t pending_reqs[$];
  out_t expected_rsps[$];
  int errors = 0;
  int cfg_hold = 0;
  int rx_stall = 0;
  int tx_gap = 0;
  bit long_hold_req = 1'b0;
  longint cycles = 0;

  task automatic clear_graph();
    for (int i = 0; i <= NODES_CAP; i++) begin
      g_head[i] = 0; w_order[i] = 0; w_on[i] = 0; w_comp[i] = 0;
    end
    for (int i = 0; i <= NODES_CAP + 1; i++) begin
      c_size[i] = 0; c_out[i] = 0;
    end
    g_stored = 0; g_overflow = 0; w_top = 0; w_cnt = 0; c_cnt = 0;
  endtask

  task automatic scc_walk(int unsigned root, int unsigned n);
    int unsigned depth, u, e, v, c, w, p;
    f_node[0] = root;
    f_edge[0] = g_head[root];
    w_cnt++;
    w_order[root] = w_cnt; w_low[root] = w_cnt;
    w_on[root] = 1;
    w_stack[w_top++] = root;
    depth = 1;
    while (depth > 0) begin
      u = f_node[depth-1];
      e = f_edge[depth-1];
      if (e != 0 && e <= EDGES_CAP) begin
        v = g_target[e];
        f_edge[depth-1] = g_link[e];
        if (v == 0 || v > n) continue;
        if (w_order[v] == 0) begin
          w_cnt++;
          w_order[v] = w_cnt; w_low[v] = w_cnt;
          w_on[v] = 1;
          w_stack[w_top++] = v;
          f_node[depth] = v;
          f_edge[depth] = g_head[v];
          depth++;
        end else if (w_on[v] && w_order[v] < w_low[u]) begin
          w_low[u] = w_order[v];
        end
        continue;
      end
      if (w_low[u] == w_order[u]) begin
        c_cnt++;
        c = c_cnt;
        while (w_top > 0) begin
          w_top--;
          w = w_stack[w_top];
          w_on[w] = 0;
          w_comp[w] = c;
          c_size[c]++;
          if (w == u) break;
        end
      end
      depth--;
      if (depth > 0) begin
        p = f_node[depth-1];
        if (w_low[u] < w_low[p]) w_low[p] = w_low[u];
      end
    end
  endtask

  task automatic predict_request(in_t r);
    int unsigned n, e, v, sinks, sink_sz;
    out_t rsp;
    if (r.req_type == REQ_ADD) begin
      if (r.src_node == 0 || r.src_node > NODES_CAP ||
          r.dst_node == 0 || r.dst_node > NODES_CAP) return;
      if (g_stored >= EDGES_CAP) begin
        g_overflow = 1;
        return;
      end
      g_stored++;
      g_target[g_stored] = r.dst_node;
      g_link[g_stored] = g_head[r.src_node];
      g_head[r.src_node] = g_stored;
      return;
    end
    n = (g_nodes > NODES_CAP) ? NODES_CAP : g_nodes;
    for (int unsigned i = 1; i <= n; i++)
      if (w_order[i] == 0) scc_walk(i, n);
    for (int unsigned i = 1; i <= n; i++) begin
      e = g_head[i];
      while (e != 0) begin
        v = g_target[e];
        if (v >= 1 && v <= n && w_comp[i] != w_comp[v]) c_out[w_comp[i]] = 1;
        e = g_link[e];
      end
    end
    sinks = 0; sink_sz = 0;
    for (int unsigned c = 1; c <= c_cnt; c++)
      if (!c_out[c]) begin
        sinks++;
        sink_sz = c_size[c];
      end
    rsp.sink_node_count = (sinks == 1) ? sink_sz[FIELD_W-1:0] : '0;
    rsp.component_count = c_cnt[FIELD_W-1:0];
    rsp.edge_overflow = g_overflow;
    expected_rsps.push_back(rsp);
    clear_graph();
  endtask

  function automatic in_t make_edge(int unsigned s, int unsigned d);
    in_t r;
    r.req_type = REQ_ADD;
    r.src_node = s[FIELD_W-1:0];
    r.dst_node = d[FIELD_W-1:0];
    return r;
  endfunction

  function automatic in_t make_run();
    in_t r;
    r.req_type = REQ_RUN;
    r.src_node = FIELD_W'($urandom);
    r.dst_node = FIELD_W'($urandom);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_ready_o) begin
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      in_valid_i <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      in_req_i <= pending_reqs[0];
      predict_request(pending_reqs.pop_front());
      in_valid_i <= 1'b1;
      tx_gap <= pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (long_hold_req) begin
      rx_stall <= 3000;
      out_ready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready_i <= (rx_stall == 1);
    end else if (out_valid_o && out_ready_i) begin
      rx_stall <= pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", out_rsp_o);
        errors++;
      end else begin
        out_t ex;
        ex = expected_rsps.pop_front();
        if (out_rsp_o.sink_node_count !== ex.sink_node_count) begin
          $error("sink_node_count expected %0d actual %0d",
                 ex.sink_node_count, out_rsp_o.sink_node_count);
          errors++;
        end
        if (out_rsp_o.component_count !== ex.component_count) begin
          $error("component_count expected %0d actual %0d",
                 ex.component_count, out_rsp_o.component_count);
          errors++;
        end
        if (out_rsp_o.edge_overflow !== ex.edge_overflow) begin
          $error("edge_overflow expected %0d actual %0d",
                 ex.edge_overflow, out_rsp_o.edge_overflow);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("scc_sink_component_count verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_nodes(int unsigned value);
    wait_drained();
    @(posedge clk_i);
    cfg_data_i <= value[FIELD_W-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    g_nodes = value;
  endtask

  task automatic queue_graph(int unsigned n, int unsigned edges, bit structured);
    int unsigned s, d, blk;
    blk = $urandom_range(1, 4);
    for (int unsigned k = 0; k < edges; k++) begin
      if (!structured || $urandom_range(0, 9) == 0) begin
        s = $urandom_range(0, 2047);
        d = $urandom_range(0, 2047);
        if ($urandom_range(0, 2) != 0) begin
          s = $urandom_range(0, n + 2);
          d = $urandom_range(0, n + 2);
        end
      end else begin
        s = $urandom_range(1, n);
        d = ((s - 1) / blk == ($urandom_range(1, n) - 1) / blk) ?
            $urandom_range(1, n) : s + ($urandom_range(0, 1) ? 1 : 0);
        if (d > n || d == 0) d = $urandom_range(1, n);
      end
      pending_reqs.push_back(make_edge(s, d));
    end
    pending_reqs.push_back(make_run());
  endtask

  initial begin
    int unsigned n;
    g_nodes = 1;
    clear_graph();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single node, loops, zero endpoints, out-of-range, both extremes
    pending_reqs.push_back(make_run());
    pending_reqs.push_back(make_edge(1, 1));
    pending_reqs.push_back(make_edge(0, 1));
    pending_reqs.push_back(make_edge(1, 2047));
    pending_reqs.push_back(make_run());
    write_nodes(4);
    pending_reqs.push_back(make_edge(1, 2));
    pending_reqs.push_back(make_edge(2, 1));
    pending_reqs.push_back(make_edge(3, 4));
    pending_reqs.push_back(make_edge(4, 5));
    pending_reqs.push_back(make_edge(1024, 1));
    pending_reqs.push_back(make_edge(1025, 1));
    pending_reqs.push_back(make_run());
    pending_reqs.push_back(make_edge(1, 2));
    pending_reqs.push_back(make_edge(2, 3));
    pending_reqs.push_back(make_run());
    write_nodes(0);
    pending_reqs.push_back(make_edge(1, 2));
    pending_reqs.push_back(make_run());
    write_nodes(2047);
    pending_reqs.push_back(make_edge(1024, 1023));
    pending_reqs.push_back(make_edge(1023, 1024));
    pending_reqs.push_back(make_edge(2046, 1));
    pending_reqs.push_back(make_run());
    write_nodes(1024);
    pending_reqs.push_back(make_run());

    // random graphs, one long receiver hold during the first
    for (int ph = 0; ph < 60; ph++) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100) : $urandom_range(1, 12);
      write_nodes(n);
      for (int g = 0; g < 2; g++)
        queue_graph(n == 0 ? 1 : n, $urandom_range(0, 28), $urandom_range(0, 4) != 0);
      if (ph == 0) begin
        for (int k = 0; k < 6; k++) queue_graph(5, 6, 1'b1);
        long_hold_req <= 1'b1;
        @(posedge clk_i);
        long_hold_req <= 1'b0;
      end
    end

    wait_drained();
    repeat (NODES_CAP * 2 + 100) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("scc_sink_component_count verification clean");
    end else begin
      $display("scc_sink_component_count verification failed");
    end
    $finish;
  end

endmodule
